[hw/rtl/cdte_pkg.sv]
// shared types and constants of the caption triple extractor
// no dependencies

package cdte_pkg;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       buffers_emptied;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] head_byte;
    logic [7:0] cc_byte_one;
    logic [7:0] cc_byte_two;
    logic [1:0] found_type;
    logic       overflow_608;
    logic       overflow_708;
    logic       last_result;
  } out_t;

  // one queue entry: the results caused by one request
  typedef struct packed {
    logic       trip_vld;
    logic       is_708;
    logic [1:0] head;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       sum_vld;
    logic [1:0] found;
    logic       ovf_608;
    logic       ovf_708;
  } rec_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TRIPLES = 2'd1,
    PH_SKIP    = 2'd2
  } phase_t;

  localparam logic [1:0] KIND_608     = 2'd0;
  localparam logic [1:0] KIND_708     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] FOUND_NONE = 2'd0;
  localparam logic [1:0] FOUND_608  = 2'd1;
  localparam logic [1:0] FOUND_708  = 2'd2;

  localparam logic [1:0] FIELD_TOP    = 2'd1;
  localparam logic [1:0] FIELD_BOTTOM = 2'd2;

  localparam logic       REG_CAP_608 = 1'b0;
  localparam logic       REG_CAP_708 = 1'b1;
  localparam int         CFG_W       = 13;
  localparam logic [12:0] CAP_RESET  = 13'd4096;

  localparam logic [2:0] POS_ID_CHECK = 3'd4;
  localparam logic [2:0] POS_FLAGS    = 3'd5;
  localparam logic [2:0] POS_EM_DATA  = 3'd6;
  localparam logic [2:0] POS_END      = 3'd7;

  localparam logic [7:0] TYPE_CODE    = 8'h03;
  localparam logic [7:0] PROC_CC_FLAG = 8'h40;
  localparam logic [7:0] COUNT_MASK   = 8'h1f;
  localparam logic [7:0] MARKER_MASK  = 8'hf8;
  localparam int         VALID_BIT    = 2;
  localparam int         TYPE_708_BIT = 1;

  localparam logic [1:0] SLOT_FLAGS = 2'd0;
  localparam logic [1:0] SLOT_DATA1 = 2'd1;
  localparam logic [1:0] SLOT_DATA2 = 2'd2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

endpackage

[hw/rtl/cdte_front.sv]
// front end: byte parser, capacity registers, fill counts and overflow flags
// depends on cdte_pkg

module cdte_front #(
  parameter int MAX_BUFFER_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cdte_pkg::in_t              in_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [cdte_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       q_full,
  output logic                       q_push,
  output cdte_pkg::rec_t             q_rec
);
  import cdte_pkg::*;

  localparam logic [16:0] MAX_ROOM = 17'(MAX_BUFFER_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [4:0]  pairs_r, pairs_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [12:0] fill_608_r, fill_608_nxt;
  logic [12:0] fill_708_r, fill_708_nxt;
  logic        ovf_608_r, ovf_608_nxt;
  logic        ovf_708_r, ovf_708_nxt;
  logic [12:0] cap_608_r, cap_708_r;
  logic [16:0] room_608, room_708;
  logic        fits_608, fits_708;
  logic        accept;
  logic [7:0]  b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.packet_byte;

  assign room_608 = ({4'b0, cap_608_r} > MAX_ROOM) ? MAX_ROOM : {4'b0, cap_608_r};
  assign room_708 = ({4'b0, cap_708_r} > MAX_ROOM) ? MAX_ROOM : {4'b0, cap_708_r};

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    pairs_nxt    = pairs_r;
    slot_nxt     = slot_r;
    flags_nxt    = flags_r;
    data_nxt     = data_r;
    seen_nxt     = seen_r;
    fill_608_nxt = in_data.buffers_emptied ? 13'd0 : fill_608_r;
    fill_708_nxt = in_data.buffers_emptied ? 13'd0 : fill_708_r;
    ovf_608_nxt  = in_data.buffers_emptied ? 1'b0 : ovf_608_r;
    ovf_708_nxt  = in_data.buffers_emptied ? 1'b0 : ovf_708_r;
    fits_608     = ({4'b0, fill_608_nxt} + 17'd3) <= room_608;
    fits_708     = ({4'b0, fill_708_nxt} + 17'd3) <= room_708;
    q_rec        = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r == POS_ID_CHECK && b != TYPE_CODE) begin
          phase_nxt = PH_SKIP;
        end else if (pos_r == POS_FLAGS) begin
          if ((b & PROC_CC_FLAG) == 8'h00) begin
            phase_nxt = PH_SKIP;
          end else begin
            pairs_nxt = b[4:0] & COUNT_MASK[4:0];
          end
        end else if (pos_r == POS_EM_DATA) begin
          slot_nxt  = SLOT_FLAGS;
          phase_nxt = (pairs_r == 5'd0) ? PH_SKIP : PH_TRIPLES;
        end
        if (pos_r != POS_END) begin
          pos_nxt = pos_r + 3'd1;
        end
      end
      PH_TRIPLES: begin
        if (slot_r == SLOT_FLAGS) begin
          if ((b & MARKER_MASK) != MARKER_MASK) begin
            phase_nxt = PH_SKIP;
          end else begin
            flags_nxt = b[2:0];
            slot_nxt  = SLOT_DATA1;
          end
        end else if (slot_r == SLOT_DATA1) begin
          data_nxt = b;
          slot_nxt = SLOT_DATA2;
        end else begin
          slot_nxt = SLOT_FLAGS;
          if (flags_r[VALID_BIT]) begin
            if (flags_r[TYPE_708_BIT]) begin
              seen_nxt[1] = 1'b1;
              if (!fits_708) begin
                ovf_708_nxt = 1'b1;
              end else begin
                fill_708_nxt   = fill_708_nxt + 13'd3;
                q_rec.trip_vld = 1'b1;
                q_rec.is_708   = 1'b1;
                q_rec.head     = flags_r[1:0];
              end
            end else begin
              seen_nxt[0] = 1'b1;
              if (!fits_608) begin
                ovf_608_nxt = 1'b1;
              end else begin
                fill_608_nxt   = fill_608_nxt + 13'd3;
                q_rec.trip_vld = 1'b1;
                q_rec.is_708   = 1'b0;
                q_rec.head     = flags_r[0] ? FIELD_BOTTOM : FIELD_TOP;
              end
            end
          end
          pairs_nxt = pairs_r - 5'd1;
          if (pairs_nxt == 5'd0) begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      default: begin
      end
    endcase
    q_rec.b1      = data_r;
    q_rec.b2      = b;
    q_rec.sum_vld = in_data.last_byte;
    q_rec.found   = seen_nxt[1] ? FOUND_708 : (seen_nxt[0] ? FOUND_608 : FOUND_NONE);
    q_rec.ovf_608 = ovf_608_nxt;
    q_rec.ovf_708 = ovf_708_nxt;
    if (in_data.last_byte) begin
      phase_nxt = PH_HEADER;
      pos_nxt   = 3'd0;
      pairs_nxt = 5'd0;
      slot_nxt  = SLOT_FLAGS;
      flags_nxt = 3'd0;
      data_nxt  = 8'd0;
      seen_nxt  = 2'd0;
    end
  end

  assign q_push = accept && (q_rec.trip_vld || q_rec.sum_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= 3'd0;
      pairs_r    <= 5'd0;
      slot_r     <= SLOT_FLAGS;
      flags_r    <= 3'd0;
      data_r     <= 8'd0;
      seen_r     <= 2'd0;
      fill_608_r <= 13'd0;
      fill_708_r <= 13'd0;
      ovf_608_r  <= 1'b0;
      ovf_708_r  <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      pairs_r    <= pairs_nxt;
      slot_r     <= slot_nxt;
      flags_r    <= flags_nxt;
      data_r     <= data_nxt;
      seen_r     <= seen_nxt;
      fill_608_r <= fill_608_nxt;
      fill_708_r <= fill_708_nxt;
      ovf_608_r  <= ovf_608_nxt;
      ovf_708_r  <= ovf_708_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_608_r <= CAP_RESET;
      cap_708_r <= CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_CAP_608) begin
        cap_608_r <= cfg_wdata;
      end
      if (cfg_index == REG_CAP_708) begin
        cap_708_r <= cfg_wdata;
      end
    end
  end

  a_triples_have_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TRIPLES |-> pairs_r != 5'd0)
    else $error("triple phase with no pairs left");

  a_empty_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.buffers_emptied && !q_rec.trip_vld |=> fill_608_r == 13'd0 &&
    fill_708_r == 13'd0)
    else $error("fill counts not cleared");

endmodule

[hw/rtl/cdte_queue.sv]
// short result queue between parser and output stage
// depends on cdte_pkg

module cdte_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cdte_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output cdte_pkg::rec_t pop_rec
);
  import cdte_pkg::*;

  rec_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full     = count_r == (Q_AW+1)'(Q_DEPTH);
  assign nonempty = count_r != '0;
  assign pop_rec  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from empty queue");

endmodule

[hw/rtl/cdte_back.sv]
// output stage: expands queue entries into one or two result items
// depends on cdte_pkg

module cdte_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  cdte_pkg::rec_t q_rec,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output cdte_pkg::out_t out_data
);
  import cdte_pkg::*;

  rec_t rec_r;
  logic trip_pend_r, trip_pend_nxt;
  logic sum_pend_r, sum_pend_nxt;
  logic fire, done;

  assign out_valid = trip_pend_r || sum_pend_r;
  assign fire      = out_valid && out_ready;
  assign done      = !out_valid || (fire && !(trip_pend_r && sum_pend_r));
  assign q_pop     = q_nonempty && done;

  always_comb begin
    trip_pend_nxt = trip_pend_r;
    sum_pend_nxt  = sum_pend_r;
    if (q_pop) begin
      trip_pend_nxt = q_rec.trip_vld;
      sum_pend_nxt  = q_rec.sum_vld;
    end else if (fire) begin
      if (trip_pend_r && sum_pend_r) begin
        trip_pend_nxt = 1'b0;
      end else begin
        trip_pend_nxt = 1'b0;
        sum_pend_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_pend_r <= 1'b0;
      sum_pend_r  <= 1'b0;
    end else begin
      trip_pend_r <= trip_pend_nxt;
      sum_pend_r  <= sum_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_rec;
    end
  end

  always_comb begin
    out_data.overflow_608 = rec_r.ovf_608;
    out_data.overflow_708 = rec_r.ovf_708;
    if (trip_pend_r) begin
      out_data.kind        = rec_r.is_708 ? KIND_708 : KIND_608;
      out_data.head_byte   = rec_r.head;
      out_data.cc_byte_one = rec_r.b1;
      out_data.cc_byte_two = rec_r.b2;
      out_data.found_type  = FOUND_NONE;
      out_data.last_result = 1'b0;
    end else begin
      out_data.kind        = KIND_SUMMARY;
      out_data.head_byte   = 2'd0;
      out_data.cc_byte_one = 8'd0;
      out_data.cc_byte_two = 8'd0;
      out_data.found_type  = rec_r.found;
      out_data.last_result = 1'b1;
    end
  end

  a_summary_after_triple: assert property (@(posedge clk) disable iff (!rst_n)
    fire && trip_pend_r && sum_pend_r |=> out_valid && out_data.last_result)
    else $error("summary lost after triple");

endmodule

[hw/rtl/cc_data_triple_extractor_core.sv]
// each result is registered in the queue and then in the output stage before it shows
// throughput: one byte per cycle while the queue is not full; a byte that ends a triple and
//   the packet yields two output items, absorbed by a four-entry queue
// reset: synchronous, clears parse state, fill counts and overflow flags,
//   sets both capacities to 4096
// top level: parser, queue and output stage; depends on cdte_pkg

module cc_data_triple_extractor_core #(
  parameter int MAX_BUFFER_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cdte_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cdte_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [cdte_pkg::CFG_W-1:0] cfg_wdata
);
  import cdte_pkg::*;

  logic q_full, q_push, q_pop, q_nonempty;
  rec_t push_rec, pop_rec;

  cdte_front #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  cdte_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_rec(push_rec),
    .full    (q_full),
    .pop     (q_pop),
    .nonempty(q_nonempty),
    .pop_rec (pop_rec)
  );

  cdte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nonempty(q_nonempty),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
